// ===== rtl/absc_pkg.sv =====
`timescale 1ns / 1ps

package absc_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [0:0] REG_MAX_ATTEMPTS = 1'b0;
   localparam logic [7:0] MAX_ATTEMPTS_RESET = 8'd3;

   localparam logic [1:0] SLOT_A    = 2'd0;
   localparam logic [1:0] SLOT_B    = 2'd1;
   localparam logic [1:0] SLOT_NONE = 2'd2;

   typedef enum logic [1:0] {
      OP_INIT     = 2'd0,
      OP_SCHEDULE = 2'd1,
      OP_SELECT   = 2'd2,
      OP_CONFIRM  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_ARG   = 2'd1,
      ST_BAD_STATE = 2'd2,
      ST_ROLLBACK  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      DEC_RECOVERY = 2'd0,
      DEC_SLOT_A   = 2'd1,
      DEC_SLOT_B   = 2'd2
   } decision_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [1:0]  slot;
      logic [31:0] image_sec;
      logic [31:0] image_build;
      logic        image_a_ok;
      logic        image_b_ok;
   } cmd_type;

   typedef struct packed {
      logic [31:0] generation;
      logic        active_slot;
      logic [1:0]  trial_slot;
      logic [7:0]  attempts_left;
      logic [31:0] min_security;
      logic [31:0] confirmed_security;
      logic [31:0] pending_security;
      logic [31:0] confirmed_build;
      logic [31:0] pending_build;
   } state_type;

   localparam state_type STATE_RESET = {32'd0, 1'b0, SLOT_NONE, 8'd0, 32'd0, 32'd0,
                                        32'd0, 32'd0, 32'd0};

   typedef struct packed {
      status_type   status;
      decision_type decision;
      logic         changed;
      state_type    state;
   } result_type;

endpackage

// ===== rtl/absc_channels.sv =====
`timescale 1ns / 1ps

interface absc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [1:0]  slot;
   logic [31:0] image_sec;
   logic [31:0] image_build;
   logic        image_a_ok;
   logic        image_b_ok;

   modport source (
      output valid, opcode, slot, image_sec, image_build, image_a_ok,
             image_b_ok,
      input  ready
   );
   modport sink (
      input  valid, opcode, slot, image_sec, image_build, image_a_ok,
             image_b_ok,
      output ready
   );
endinterface

interface absc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [1:0]  decision;
   logic        changed;
   logic [31:0] generation_out;
   logic        confirmed_slot_out;
   logic [1:0]  pending_slot_out;
   logic [7:0]  attempts_left_out;
   logic [31:0] min_security_out;
   logic [31:0] pending_security_out;
   logic [31:0] confirmed_build_out;
   logic [31:0] pending_build_out;

   modport source (
      output valid, status, decision, changed, generation_out, confirmed_slot_out,
             pending_slot_out, attempts_left_out, min_security_out,
             pending_security_out, confirmed_build_out, pending_build_out,
      input  ready
   );
   modport sink (
      input  valid, status, decision, changed, generation_out, confirmed_slot_out,
             pending_slot_out, attempts_left_out, min_security_out,
             pending_security_out, confirmed_build_out, pending_build_out,
      output ready
   );
endinterface

// ===== rtl/absc_cmd_unit.sv =====
`timescale 1ns / 1ps

module absc_cmd_unit (
   input  absc_pkg::state_type  state_i,
   input  absc_pkg::cmd_type    cmd_i,
   input  logic [7:0]           max_attempts_i,
   output absc_pkg::state_type  state_o,
   output absc_pkg::result_type result_o
);

   logic        slot_bad;
   logic        state_ok;
   logic        conf_img_ok;
   logic        pend_img_ok;
   logic        booted;
   logic [31:0] gen_inc;
   logic [31:0] gen_next;

   function automatic absc_pkg::decision_type slot_decision(input logic s);
      return s ? absc_pkg::DEC_SLOT_B : absc_pkg::DEC_SLOT_A;
   endfunction

   assign slot_bad = cmd_i.slot[1];

   always_comb begin
      if (state_i.generation == 32'd0 ||
          state_i.confirmed_security != state_i.min_security) begin
         state_ok = 1'b0;
      end else if (state_i.trial_slot == absc_pkg::SLOT_NONE) begin
         state_ok = state_i.attempts_left == 8'd0 && state_i.pending_security == 32'd0 &&
                    state_i.pending_build == 32'd0;
      end else begin
         state_ok = !state_i.trial_slot[1] &&
                    state_i.trial_slot[0] != state_i.active_slot &&
                    state_i.attempts_left <= max_attempts_i &&
                    state_i.pending_security > state_i.min_security;
      end
   end

   // wrap past all ones to 1, never 0
   assign gen_inc  = state_i.generation + 32'd1;
   assign gen_next = (gen_inc == 32'd0) ? 32'd1 : gen_inc;

   assign conf_img_ok = state_i.active_slot ? cmd_i.image_b_ok : cmd_i.image_a_ok;
   assign pend_img_ok = state_i.trial_slot[0] ? cmd_i.image_b_ok : cmd_i.image_a_ok;

   always_comb begin
      state_o           = state_i;
      result_o.status   = absc_pkg::ST_OK;
      result_o.decision = absc_pkg::DEC_RECOVERY;
      result_o.changed  = 1'b0;
      booted            = 1'b0;
      case (cmd_i.opcode)
         absc_pkg::OP_INIT: begin
            if (slot_bad) begin
               result_o.status = absc_pkg::ST_BAD_ARG;
            end else begin
               state_o.generation         = 32'd1;
               state_o.active_slot        = cmd_i.slot[0];
               state_o.trial_slot         = absc_pkg::SLOT_NONE;
               state_o.attempts_left      = 8'd0;
               state_o.min_security       = cmd_i.image_sec;
               state_o.confirmed_security = cmd_i.image_sec;
               state_o.pending_security   = 32'd0;
               state_o.confirmed_build    = cmd_i.image_build;
               state_o.pending_build      = 32'd0;
               result_o.changed           = 1'b1;
            end
         end
         absc_pkg::OP_SCHEDULE: begin
            if (slot_bad) begin
               result_o.status = absc_pkg::ST_BAD_ARG;
            end else if (!state_ok || cmd_i.slot[0] == state_i.active_slot ||
                         state_i.trial_slot != absc_pkg::SLOT_NONE) begin
               result_o.status = absc_pkg::ST_BAD_STATE;
            end else if (cmd_i.image_sec <= state_i.min_security) begin
               result_o.status = absc_pkg::ST_ROLLBACK;
            end else begin
               state_o.trial_slot       = cmd_i.slot;
               state_o.attempts_left    = max_attempts_i;
               state_o.pending_security = cmd_i.image_sec;
               state_o.pending_build    = cmd_i.image_build;
               state_o.generation       = gen_next;
               result_o.changed         = 1'b1;
            end
         end
         absc_pkg::OP_SELECT: begin
            if (!state_ok) begin
               result_o.status = absc_pkg::ST_BAD_STATE;
            end else begin
               if (state_i.trial_slot != absc_pkg::SLOT_NONE) begin
                  if (pend_img_ok && state_i.attempts_left != 8'd0) begin
                     state_o.attempts_left = state_i.attempts_left - 8'd1;
                     result_o.decision     = slot_decision(state_i.trial_slot[0]);
                     booted                = 1'b1;
                  end else begin
                     state_o.trial_slot       = absc_pkg::SLOT_NONE;
                     state_o.attempts_left    = 8'd0;
                     state_o.pending_security = 32'd0;
                     state_o.pending_build    = 32'd0;
                  end
                  state_o.generation = gen_next;
                  result_o.changed   = 1'b1;
               end
               if (!booted && conf_img_ok) begin
                  result_o.decision = slot_decision(state_i.active_slot);
               end
            end
         end
         absc_pkg::OP_CONFIRM: begin
            if (slot_bad) begin
               result_o.status = absc_pkg::ST_BAD_ARG;
            end else if (!state_ok) begin
               result_o.status = absc_pkg::ST_BAD_STATE;
            end else if (state_i.trial_slot == absc_pkg::SLOT_NONE &&
                         cmd_i.slot[0] == state_i.active_slot &&
                         cmd_i.image_sec == state_i.confirmed_security &&
                         cmd_i.image_build == state_i.confirmed_build) begin
               result_o.status = absc_pkg::ST_OK;
            end else if (cmd_i.slot != state_i.trial_slot ||
                         cmd_i.image_sec != state_i.pending_security ||
                         cmd_i.image_build != state_i.pending_build) begin
               result_o.status = absc_pkg::ST_BAD_STATE;
            end else begin
               state_o.active_slot        = cmd_i.slot[0];
               state_o.min_security       = cmd_i.image_sec;
               state_o.confirmed_security = cmd_i.image_sec;
               state_o.confirmed_build    = cmd_i.image_build;
               state_o.trial_slot         = absc_pkg::SLOT_NONE;
               state_o.attempts_left      = 8'd0;
               state_o.pending_security   = 32'd0;
               state_o.pending_build      = 32'd0;
               state_o.generation         = gen_next;
               result_o.changed           = 1'b1;
            end
         end
         default: begin
            result_o.status = absc_pkg::ST_BAD_ARG;
         end
      endcase
      result_o.state = state_o;
   end

endmodule

// ===== rtl/ab_boot_slot_controller_core.sv =====
`timescale 1ns / 1ps

// A/B boot slot controller with anti-rollback.
// req_word carries one command word (initialize, schedule update, select boot,
// confirm running) with a slot, a security counter, a build version and the
// image validity flags. rsp_word returns one word per command: status, boot
// decision, changed flag and the stored state after the command.
// Commands go through the input register, then the result register.
// Throughput: one command per cycle while rsp_word is ready; the whole command
// is decoded and applied in the single stage between the input register and the
// result register. A stalled rsp_word holds its word; the input register keeps
// accepting as long as the result register frees up, so one extra word waits in
// the input register, and req_word.ready drops only when both are full. Reset
// empties both registers and clears the stored state; generation is 0 so only
// initialize succeeds until one is done. max_pending_attempts resets to 3 and
// is written through the csr_ port (byte address 0), only while idle: a rule
// for the user, left unenforced by the block itself.

module ab_boot_slot_controller_core (
   input  logic                                 clock,
   input  logic                                 reset,
   absc_req_if.sink                             req_word,
   absc_rsp_if.source                           rsp_word,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [absc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [absc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [absc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   logic                 s1_valid_ff, s1_valid_in;
   absc_pkg::cmd_type    cmd_ff, cmd_in;
   absc_pkg::state_type  state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   absc_pkg::result_type result_ff, result_in;
   logic [7:0]           max_att_ff, max_att_in;

   absc_pkg::state_type  next_state;
   absc_pkg::result_type next_result;
   absc_pkg::cmd_type    req_cmd;

   logic out_free;
   logic advance;
   logic take;
   logic csr_hit;
   logic csr_wr;

   assign out_free       = !rsp_valid_ff || rsp_word.ready;
   assign advance        = s1_valid_ff && out_free;
   assign req_word.ready = !s1_valid_ff || out_free;
   assign take           = req_word.valid && req_word.ready;

   assign req_cmd.opcode      = absc_pkg::opcode_type'(req_word.opcode);
   assign req_cmd.slot        = req_word.slot;
   assign req_cmd.image_sec   = req_word.image_sec;
   assign req_cmd.image_build = req_word.image_build;
   assign req_cmd.image_a_ok  = req_word.image_a_ok;
   assign req_cmd.image_b_ok  = req_word.image_b_ok;

   absc_cmd_unit u_cmd (
      .state_i        (state_ff),
      .cmd_i          (cmd_ff),
      .max_attempts_i (max_att_ff),
      .state_o        (next_state),
      .result_o       (next_result)
   );

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[absc_pkg::CSR_ADDR_W-1:2] == absc_pkg::REG_MAX_ATTEMPTS;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? {{(absc_pkg::CSR_DATA_W-8){1'b0}}, max_att_ff}
                               : '0;

   always_comb begin
      s1_valid_in  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      cmd_in       = take ? req_cmd : cmd_ff;
      state_in     = advance ? next_state : state_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_word.ready ? 1'b0 : rsp_valid_ff);
      result_in    = advance ? next_result : result_ff;
      max_att_in   = csr_wr ? csr_pwdata[7:0] : max_att_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_att_ff   <= absc_pkg::MAX_ATTEMPTS_RESET;
         state_ff     <= absc_pkg::STATE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         max_att_ff   <= max_att_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      result_ff <= result_in;
   end

   assign rsp_word.valid                = rsp_valid_ff;
   assign rsp_word.status               = result_ff.status;
   assign rsp_word.decision             = result_ff.decision;
   assign rsp_word.changed              = result_ff.changed;
   assign rsp_word.generation_out       = result_ff.state.generation;
   assign rsp_word.confirmed_slot_out   = result_ff.state.active_slot;
   assign rsp_word.pending_slot_out     = result_ff.state.trial_slot;
   assign rsp_word.attempts_left_out    = result_ff.state.attempts_left;
   assign rsp_word.min_security_out     = result_ff.state.min_security;
   assign rsp_word.pending_security_out = result_ff.state.pending_security;
   assign rsp_word.confirmed_build_out  = result_ff.state.confirmed_build;
   assign rsp_word.pending_build_out    = result_ff.state.pending_build;

`ifndef SYNTH
   a_changed_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.changed |-> result_ff.status == absc_pkg::ST_OK)
      else $error("changed word with failing status");

   a_ok_has_generation: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.status == absc_pkg::ST_OK |->
         result_ff.state.generation != 32'd0)
      else $error("ok word with zero generation");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state moved without a word");

   a_state_matches_word: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && result_ff.state == state_ff)
      else $error("result word does not match stored state");
`endif

endmodule

// ===== sim/absc_boot_checker.sv =====
`timescale 1ns / 1ps

module absc_boot_checker (
   input  logic                               clock,
   input  logic                               reset,
   absc_req_if                                req_mon,
   absc_rsp_if                                rsp_mon,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [absc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [absc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   input  logic [absc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   input  logic                               csr_pready,
   output int unsigned                        fail_count,
   output int unsigned                        results_due
);
   import absc_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ATTEMPTS_ADDR = {REG_MAX_ATTEMPTS, 2'b00};

   state_type   boot_state;
   logic [7:0]  attempt_limit;
   result_type  expected_results [$];
   int unsigned results_seen;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] result %0d: %s: got %0h, expected %0h", $realtime, results_seen,
               what, got, want);
      fail_count++;
   endtask

   function automatic state_type without_trial(input state_type s);
      state_type r;
      r = s;
      r.trial_slot       = SLOT_NONE;
      r.attempts_left    = '0;
      r.pending_security = '0;
      r.pending_build    = '0;
      return r;
   endfunction

   function automatic logic [31:0] next_generation(input logic [31:0] g);
      logic [31:0] n;
      n = g + 32'd1;
      return (n == '0) ? 32'd1 : n;
   endfunction

   function automatic bit state_consistent(input state_type s, input logic [7:0] limit);
      if (s.generation == '0 || s.confirmed_security != s.min_security)
         return 1'b0;
      if (s.trial_slot == SLOT_NONE)
         return s.attempts_left == '0 && s.pending_security == '0 && s.pending_build == '0;
      return s.trial_slot <= SLOT_B && s.trial_slot != {1'b0, s.active_slot} &&
             s.attempts_left <= limit && s.pending_security > s.min_security;
   endfunction

   function automatic result_type boot_step(input cmd_type c);
      result_type r;
      state_type  s;
      logic       conf_ok;
      logic       trial_ok;
      logic       booted;
      s = boot_state;
      r = '0;
      booted = 1'b0;
      case (c.opcode)
         OP_INIT: begin
            if (c.slot > SLOT_B) begin
               r.status = ST_BAD_ARG;
            end else begin
               s = without_trial(s);
               s.generation         = 32'd1;
               s.active_slot        = c.slot[0];
               s.min_security       = c.image_sec;
               s.confirmed_security = c.image_sec;
               s.confirmed_build    = c.image_build;
               r.changed = 1'b1;
            end
         end
         OP_SCHEDULE: begin
            if (c.slot > SLOT_B) begin
               r.status = ST_BAD_ARG;
            end else if (!state_consistent(s, attempt_limit) || c.slot[0] == s.active_slot ||
                         s.trial_slot != SLOT_NONE) begin
               r.status = ST_BAD_STATE;
            end else if (c.image_sec <= s.min_security) begin
               r.status = ST_ROLLBACK;
            end else begin
               s.trial_slot       = c.slot;
               s.attempts_left    = attempt_limit;
               s.pending_security = c.image_sec;
               s.pending_build    = c.image_build;
               s.generation       = next_generation(s.generation);
               r.changed = 1'b1;
            end
         end
         OP_SELECT: begin
            if (!state_consistent(s, attempt_limit)) begin
               r.status = ST_BAD_STATE;
            end else begin
               conf_ok = s.active_slot ? c.image_b_ok : c.image_a_ok;
               if (s.trial_slot != SLOT_NONE) begin
                  trial_ok = (s.trial_slot == SLOT_A) ? c.image_a_ok : c.image_b_ok;
                  if (trial_ok && s.attempts_left != '0) begin
                     s.attempts_left = s.attempts_left - 8'd1;
                     r.decision = decision_type'(s.trial_slot + 2'd1);
                     booted = 1'b1;
                  end else begin
                     s = without_trial(s);
                  end
                  s.generation = next_generation(s.generation);
                  r.changed = 1'b1;
               end
               if (!booted && conf_ok)
                  r.decision = decision_type'({1'b0, s.active_slot} + 2'd1);
            end
         end
         default: begin
            if (c.slot > SLOT_B) begin
               r.status = ST_BAD_ARG;
            end else if (!state_consistent(s, attempt_limit)) begin
               r.status = ST_BAD_STATE;
            end else if (s.trial_slot == SLOT_NONE && c.slot[0] == s.active_slot &&
                         c.image_sec == s.confirmed_security &&
                         c.image_build == s.confirmed_build) begin
               r.status = ST_OK;
            end else if (c.slot != s.trial_slot || c.image_sec != s.pending_security ||
                         c.image_build != s.pending_build) begin
               r.status = ST_BAD_STATE;
            end else begin
               s.active_slot        = c.slot[0];
               s.min_security       = c.image_sec;
               s.confirmed_security = c.image_sec;
               s.confirmed_build    = c.image_build;
               s = without_trial(s);
               s.generation = next_generation(s.generation);
               r.changed = 1'b1;
            end
         end
      endcase
      boot_state = s;
      r.state = s;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      cmd_type    cmd;
      result_type seen;
      result_type want;
      if (reset) begin
         boot_state = '0;
         boot_state.trial_slot = SLOT_NONE;
         attempt_limit = MAX_ATTEMPTS_RESET;
         expected_results.delete();
         results_seen = 0;
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == ATTEMPTS_ADDR) begin
            if (csr_pwrite)
               attempt_limit = csr_pwdata[7:0];
            else if (csr_prdata !== CSR_DATA_W'(attempt_limit))
               report_mismatch("attempt limit readback", csr_prdata, CSR_DATA_W'(attempt_limit));
         end
         if (req_mon.valid && req_mon.ready) begin
            cmd.opcode      = opcode_type'(req_mon.opcode);
            cmd.slot        = req_mon.slot;
            cmd.image_sec   = req_mon.image_sec;
            cmd.image_build = req_mon.image_build;
            cmd.image_a_ok  = req_mon.image_a_ok;
            cmd.image_b_ok  = req_mon.image_b_ok;
            expected_results.push_back(boot_step(cmd));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.status                   = status_type'(rsp_mon.status);
            seen.decision                 = decision_type'(rsp_mon.decision);
            seen.changed                  = rsp_mon.changed;
            seen.state.generation         = rsp_mon.generation_out;
            seen.state.active_slot        = rsp_mon.confirmed_slot_out;
            seen.state.trial_slot         = rsp_mon.pending_slot_out;
            seen.state.attempts_left      = rsp_mon.attempts_left_out;
            seen.state.min_security       = rsp_mon.min_security_out;
            seen.state.confirmed_security = '0;
            seen.state.pending_security   = rsp_mon.pending_security_out;
            seen.state.confirmed_build    = rsp_mon.confirmed_build_out;
            seen.state.pending_build      = rsp_mon.pending_build_out;
            if (expected_results.size() == 0) begin
               report_mismatch("word with nothing expected", seen.state.generation, '0);
            end else begin
               want = expected_results.pop_front();
               if (seen.status !== want.status)
                  report_mismatch("status", 32'(seen.status), 32'(want.status));
               if (seen.decision !== want.decision)
                  report_mismatch("decision", 32'(seen.decision), 32'(want.decision));
               if (seen.changed !== want.changed)
                  report_mismatch("changed", 32'(seen.changed), 32'(want.changed));
               if (seen.state.generation !== want.state.generation)
                  report_mismatch("generation", seen.state.generation, want.state.generation);
               if (seen.state.active_slot !== want.state.active_slot)
                  report_mismatch("confirmed slot", 32'(seen.state.active_slot),
                                  32'(want.state.active_slot));
               if (seen.state.trial_slot !== want.state.trial_slot)
                  report_mismatch("pending slot", 32'(seen.state.trial_slot),
                                  32'(want.state.trial_slot));
               if (seen.state.attempts_left !== want.state.attempts_left)
                  report_mismatch("attempts left", 32'(seen.state.attempts_left),
                                  32'(want.state.attempts_left));
               if (seen.state.min_security !== want.state.min_security)
                  report_mismatch("min security", seen.state.min_security,
                                  want.state.min_security);
               if (seen.state.pending_security !== want.state.pending_security)
                  report_mismatch("pending security", seen.state.pending_security,
                                  want.state.pending_security);
               if (seen.state.confirmed_build !== want.state.confirmed_build)
                  report_mismatch("confirmed build", seen.state.confirmed_build,
                                  want.state.confirmed_build);
               if (seen.state.pending_build !== want.state.pending_build)
                  report_mismatch("pending build", seen.state.pending_build,
                                  want.state.pending_build);
            end
            results_seen++;
         end
      end
      results_due = expected_results.size();
   end

endmodule

// ===== sim/ab_boot_slot_controller_core_tb.sv =====
`timescale 1ns / 1ps

module ab_boot_slot_controller_core_tb;
   import absc_pkg::*;

   localparam real CLOCK_PERIOD   = 8.0;
   localparam int  RANDOM_ITEMS   = 510;
   localparam int  PHASES         = 6;
   localparam int  HOLD_CYCLES    = 200;
   localparam int  WATCHDOG_LIMIT = 2000;
   localparam logic [CSR_ADDR_W-1:0] ATTEMPTS_ADDR = {REG_MAX_ATTEMPTS, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int unsigned fail_count;
   int unsigned results_due;
   int unsigned sent_words = 0;
   int unsigned quiet_cycles = 0;
   logic        hold_pending = 1'b0;
   logic        tail_phase = 1'b0;

   logic        assumed_valid = 1'b0;
   logic        assumed_slot;
   logic [31:0] assumed_security;
   logic [31:0] assumed_build;
   logic [7:0]  attempt_limit_now;

   absc_req_if req_bus ();
   absc_rsp_if rsp_bus ();

   ab_boot_slot_controller_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_bus),
      .rsp_word    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   absc_boot_checker boot_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_word(input opcode_type op, input logic [1:0] slot,
                            input logic [31:0] sec, input logic [31:0] build,
                            input logic a_ok, input logic b_ok);
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.slot        <= slot;
      req_bus.image_sec   <= sec;
      req_bus.image_build <= build;
      req_bus.image_a_ok  <= a_ok;
      req_bus.image_b_ok  <= b_ok;
      do @(posedge clock); while (!req_bus.ready);
      sent_words++;
      if (!tail_phase && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic write_en, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_en;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_attempt_limit(input logic [7:0] value);
      settle();
      csr_access(1'b1, ATTEMPTS_ADDR, CSR_DATA_W'(value));
      csr_access(1'b0, ATTEMPTS_ADDR, '0);
      attempt_limit_now = value;
   endtask

   // init (sometimes), schedule, a few boots, then confirm / mismatch / skip
   task automatic run_update_cycle();
      logic [1:0]  t_slot;
      logic [31:0] t_sec;
      logic [31:0] t_build;
      logic        t_ok;
      logic        armed;
      logic        promoted;
      int unsigned att;
      int unsigned kind;
      if (!assumed_valid || $urandom_range(0, 3) == 0) begin
         assumed_slot = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0:       assumed_security = '0;
            1:       assumed_security = $urandom();
            default: assumed_security = $urandom_range(0, 5000);
         endcase
         assumed_build = $urandom();
         send_word(OP_INIT, {1'b0, assumed_slot}, assumed_security, assumed_build,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         assumed_valid = 1'b1;
      end
      t_slot   = {1'b0, ~assumed_slot};
      t_sec    = assumed_security + $urandom_range(1, 3000);
      t_build  = $urandom();
      promoted = 1'b0;
      kind = $urandom_range(0, 15);
      if (kind == 0)
         t_slot = {1'b0, assumed_slot};
      else if (kind == 1)
         t_slot = 2'($urandom_range(2, 3));
      else if (kind == 2)
         t_sec = assumed_security - $urandom_range(0, 1);
      else if (kind == 3)
         t_sec = $urandom();
      send_word(OP_SCHEDULE, t_slot, t_sec, t_build, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      armed = (t_slot == {1'b0, ~assumed_slot}) && (t_sec > assumed_security);
      att = 32'(attempt_limit_now);
      repeat ($urandom_range(0, 4)) begin
         t_ok = ($urandom_range(0, 5) != 0);
         send_word(OP_SELECT, 2'($urandom_range(0, 3)), $urandom(), $urandom(),
                   (t_slot == SLOT_A) ? t_ok : 1'($urandom_range(0, 1)),
                   (t_slot == SLOT_B) ? t_ok : 1'($urandom_range(0, 1)));
         if (armed) begin
            if (t_ok && att > 0)
               att--;
            else
               armed = 1'b0;
         end
      end
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         send_word(OP_CONFIRM, t_slot, t_sec, t_build, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
         if (armed) begin
            assumed_slot     = t_slot[0];
            assumed_security = t_sec;
            assumed_build    = t_build;
            promoted = 1'b1;
         end
      end else if (kind == 7) begin
         send_word(OP_CONFIRM, t_slot, t_sec, t_build ^ (32'd1 << $urandom_range(0, 31)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (kind == 8) begin
         send_word(OP_CONFIRM, {1'b0, assumed_slot}, assumed_security, assumed_build,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      if (armed && !promoted)
         assumed_valid = 1'b0;
   endtask

   initial begin : result_drain
      int unsigned run_len;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            run_len = HOLD_CYCLES;
         end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            run_len = $urandom_range(1, 8);
         end else begin
            rsp_bus.ready <= 1'b1;
            run_len = $urandom_range(1, 16);
         end
         repeat (run_len) @(posedge clock);
      end
   end

   initial begin : stimulus
      int unsigned phase_goal;
      logic [7:0]  phase_limit;
      opcode_type  noise_op;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= '0;
      req_bus.slot        <= '0;
      req_bus.image_sec   <= '0;
      req_bus.image_build <= '0;
      req_bus.image_a_ok  <= 1'b0;
      req_bus.image_b_ok  <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      attempt_limit_now = MAX_ATTEMPTS_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // nothing initialized yet
      send_word(OP_SELECT, SLOT_A, '0, '0, 1'b1, 1'b1);
      send_word(OP_SCHEDULE, SLOT_B, 32'd5, 32'd5, 1'b0, 1'b0);
      send_word(OP_INIT, 2'd2, '0, '0, 1'b0, 1'b0);
      send_word(OP_INIT, 2'd3, '1, '1, 1'b1, 1'b1);
      send_word(OP_INIT, SLOT_A, 32'd10, 32'd100, 1'b0, 1'b0);
      send_word(OP_SCHEDULE, 2'd3, 32'd50, 32'd1, 1'b0, 1'b0);
      send_word(OP_SCHEDULE, SLOT_A, 32'd50, 32'd1, 1'b0, 1'b0);
      send_word(OP_SCHEDULE, SLOT_B, 32'd10, 32'd1, 1'b0, 1'b0);
      send_word(OP_SCHEDULE, SLOT_B, '1, '1, 1'b0, 1'b0);
      send_word(OP_SCHEDULE, SLOT_B, 32'd20, 32'd1, 1'b0, 1'b0);
      send_word(OP_CONFIRM, SLOT_B, '1, 32'hFFFF_FFFE, 1'b0, 1'b0);
      // use up every trial boot, then fall back
      repeat (3) send_word(OP_SELECT, SLOT_A, '0, '0, 1'b0, 1'b1);
      send_word(OP_SELECT, SLOT_A, '0, '0, 1'b1, 1'b1);
      send_word(OP_SELECT, SLOT_A, '0, '0, 1'b0, 1'b0);
      send_word(OP_CONFIRM, SLOT_A, 32'd10, 32'd100, 1'b0, 1'b0);
      send_word(OP_CONFIRM, 2'd2, 32'd10, 32'd100, 1'b0, 1'b0);
      send_word(OP_SCHEDULE, SLOT_B, 32'd20, 32'd7, 1'b0, 1'b0);
      send_word(OP_SELECT, SLOT_A, '0, '0, 1'b1, 1'b0);
      send_word(OP_SCHEDULE, SLOT_B, 32'd20, 32'd7, 1'b0, 1'b0);
      send_word(OP_CONFIRM, SLOT_B, 32'd20, 32'd7, 1'b0, 1'b0);
      send_word(OP_SCHEDULE, SLOT_A, 32'd30, 32'd8, 1'b0, 1'b0);
      // drop the limit below the armed attempts
      set_attempt_limit(8'd1);
      send_word(OP_SELECT, SLOT_A, '0, '0, 1'b1, 1'b1);
      send_word(OP_CONFIRM, SLOT_A, 32'd30, 32'd8, 1'b0, 1'b0);
      send_word(OP_INIT, SLOT_B, '0, '0, 1'b0, 1'b0);
      send_word(OP_INIT, SLOT_A, '1, '1, 1'b1, 1'b1);
      send_word(OP_SCHEDULE, SLOT_B, '1, 32'd3, 1'b0, 1'b0);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       phase_limit = 8'd0;
            1:       phase_limit = 8'd255;
            2:       phase_limit = 8'd1;
            3:       phase_limit = 8'd2;
            4:       phase_limit = 8'($urandom_range(4, 254));
            default: phase_limit = MAX_ATTEMPTS_RESET;
         endcase
         set_attempt_limit(phase_limit);
         if (phase == 2)
            hold_pending = 1'b1;
         if (phase == PHASES - 1)
            tail_phase = 1'b1;
         assumed_valid = 1'b0;
         phase_goal = sent_words + RANDOM_ITEMS / PHASES;
         while (sent_words < phase_goal) begin
            if ($urandom_range(0, 6) == 0) begin
               noise_op = opcode_type'($urandom_range(0, 3));
               send_word(noise_op, 2'($urandom_range(0, 3)),
                         ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 40),
                         $urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               assumed_valid = 1'b0;
            end else begin
               run_update_cycle();
            end
         end
      end

      settle();
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/absc_pkg.sv
rtl/absc_channels.sv
rtl/absc_cmd_unit.sv
rtl/ab_boot_slot_controller_core.sv
sim/absc_boot_checker.sv
sim/ab_boot_slot_controller_core_tb.sv
